>>> hw/rtl/sensor_row_frame_deframer_top_macros.svh
// Assertion macros shared by the deframer RTL.
`ifndef SENSOR_ROW_FRAME_DEFRAMER_TOP_MACROS_SVH
`define SENSOR_ROW_FRAME_DEFRAMER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define SRFD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("srfd assertion failed");
`define SRFD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("srfd assertion failed");
`else
`define SRFD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SRFD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hw/rtl/srfd_pkg.sv
// Types and constants shared by the deframer modules.
package srfd_pkg;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_END   = 1'b1;

	localparam logic [7:0] SYNC_0   = 8'hAA;
	localparam logic [7:0] SYNC_1   = 8'h55;
	localparam logic [7:0] SYNC_2   = 8'h00;
	localparam logic [7:0] CMD_ROWS = 8'h24;
	localparam logic [7:0] END_CR   = 8'h0D;
	localparam logic [7:0] END_LF   = 8'h0A;

	localparam logic [15:0] LEN_160X120 = 16'd321;
	localparam logic [15:0] LEN_120X120 = 16'd241;
	localparam logic [15:0] LEN_80X80   = 16'd161;
	localparam logic [15:0] LEN_LIMIT   = 16'd1000;

	localparam int TDATA_W = 104;

	typedef struct packed {
		logic        kind;
		logic [7:0]  row;
		logic [8:0]  column;
		logic [15:0] pixel_value;
		logic [7:0]  frame_command;
		logic        trailer_ok;
		logic        image_complete;
		logic [6:0]  image_height;
		logic [7:0]  image_width;
		logic [15:0] header_check;
		logic [15:0] trailer_check;
	} res_t;

endpackage

>>> hw/rtl/srfd_parse.sv
// Front end: frame parser that turns each accepted byte into at most one result.
`include "sensor_row_frame_deframer_top_macros.svh"

module srfd_parse
	import srfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_beat,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	output res_t       res
);

	typedef enum logic [3:0] {
		ST_WAIT_AA, ST_WANT_55, ST_WANT_00, ST_CMD, ST_LEN_HI, ST_LEN_LO,
		ST_HCK_HI, ST_HCK_LO, ST_PAYLOAD, ST_TCK_HI, ST_TCK_LO, ST_END_0D, ST_END_0A
	} state_t;

	state_t      state_q, state_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [15:0] len_q, len_d;
	logic [15:0] hck_q, hck_d;
	logic [15:0] tck_q, tck_d;
	logic [7:0]  row_q, row_d;
	logic [7:0]  high_q, high_d;
	logic [8:0]  pairs_q, pairs_d;
	logic [15:0] pos_q, pos_d;
	logic [6:0]  height_q, height_d;
	logic [7:0]  width_q, width_d;
	logic        rows_active;
	logic        good_end;
	logic        done;

	assign rows_active = (cmd_q == CMD_ROWS) && (len_q != '0) && (len_q < LEN_LIMIT);

	always_comb begin
		state_d  = state_q;
		cmd_d    = cmd_q;
		len_d    = len_q;
		hck_d    = hck_q;
		tck_d    = tck_q;
		row_d    = row_q;
		high_d   = high_q;
		pairs_d  = pairs_q;
		pos_d    = pos_q;
		height_d = height_q;
		width_d  = width_q;
		good_end = 1'b0;
		done     = 1'b0;
		res_valid = 1'b0;
		res.kind           = KIND_PIXEL;
		res.row            = row_q;
		res.column         = pairs_q;
		res.pixel_value    = {high_q, rx_byte};
		res.frame_command  = cmd_q;
		res.trailer_ok     = 1'b0;
		res.image_complete = 1'b0;
		res.image_height   = height_q;
		res.image_width    = width_q;
		res.header_check   = hck_q;
		res.trailer_check  = '0;
		case (state_q)
			ST_WAIT_AA: begin
				if (rx_byte == SYNC_0) state_d = ST_WANT_55;
			end
			ST_WANT_55: state_d = (rx_byte == SYNC_1) ? ST_WANT_00 : ST_WAIT_AA;
			ST_WANT_00: state_d = (rx_byte == SYNC_2) ? ST_CMD : ST_WAIT_AA;
			ST_CMD: begin
				cmd_d   = rx_byte;
				row_d   = '0;
				pairs_d = '0;
				high_d  = '0;
				tck_d   = '0;
				state_d = ST_LEN_HI;
			end
			ST_LEN_HI: begin
				len_d   = {rx_byte, 8'h00};
				state_d = ST_LEN_LO;
			end
			ST_LEN_LO: begin
				len_d   = {len_q[15:8], rx_byte};
				state_d = ST_HCK_HI;
			end
			ST_HCK_HI: begin
				hck_d   = {rx_byte, 8'h00};
				state_d = ST_HCK_LO;
			end
			ST_HCK_LO: begin
				hck_d   = {hck_q[15:8], rx_byte};
				pos_d   = '0;
				state_d = (len_q == '0) ? ST_TCK_HI : ST_PAYLOAD;
			end
			ST_PAYLOAD: begin
				if (rows_active) begin
					if (pos_q == '0) begin
						row_d = rx_byte;
					end else if (pos_q[0]) begin
						high_d = rx_byte;
					end else begin
						res_valid = 1'b1;
						pairs_d   = pairs_q + 9'd1;
					end
				end
				pos_d = pos_q + 16'd1;
				if (({1'b0, pos_q} + 17'd1) >= {1'b0, len_q}) state_d = ST_TCK_HI;
			end
			ST_TCK_HI: begin
				tck_d   = {rx_byte, 8'h00};
				state_d = ST_TCK_LO;
			end
			ST_TCK_LO: begin
				tck_d   = {tck_q[15:8], rx_byte};
				state_d = ST_END_0D;
			end
			ST_END_0D: begin
				if (rx_byte != END_CR) begin
					res_valid = 1'b1;
					state_d   = ST_WAIT_AA;
				end else begin
					state_d = ST_END_0A;
				end
			end
			ST_END_0A: begin
				good_end  = (rx_byte == END_LF);
				res_valid = 1'b1;
				state_d   = ST_WAIT_AA;
			end
			default: state_d = ST_WAIT_AA;
		endcase

		if (good_end && cmd_q == CMD_ROWS) begin
			if (len_q == LEN_160X120) begin
				height_d = 7'd120;
				width_d  = 8'd160;
			end else if (len_q == LEN_120X120) begin
				height_d = 7'd120;
				width_d  = 8'd120;
			end else if (len_q == LEN_80X80) begin
				height_d = 7'd80;
				width_d  = 8'd80;
			end
			done = rows_active && (height_d != '0) &&
				(row_q == ({1'b0, height_d} - 8'd1)) && (pairs_q == {1'b0, width_d});
		end

		if (state_q == ST_END_0D || state_q == ST_END_0A) begin
			res.kind           = KIND_END;
			res.pixel_value    = '0;
			res.trailer_ok     = good_end;
			res.image_complete = done;
			res.image_height   = height_d;
			res.image_width    = width_d;
			res.trailer_check  = tck_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_WAIT_AA;
			cmd_q    <= '0;
			len_q    <= '0;
			hck_q    <= '0;
			tck_q    <= '0;
			row_q    <= '0;
			high_q   <= '0;
			pairs_q  <= '0;
			pos_q    <= '0;
			height_q <= '0;
			width_q  <= '0;
		end else if (in_beat) begin
			state_q  <= state_d;
			cmd_q    <= cmd_d;
			len_q    <= len_d;
			hck_q    <= hck_d;
			tck_q    <= tck_d;
			row_q    <= row_d;
			high_q   <= high_d;
			pairs_q  <= pairs_d;
			pos_q    <= pos_d;
			height_q <= height_d;
			width_q  <= width_d;
		end
	end

	`SRFD_ASSERT_IMP(a_pixel_only_rows, clk, arst_n,
		res_valid && res.kind == KIND_PIXEL, cmd_q == CMD_ROWS && state_q == ST_PAYLOAD)
	`SRFD_ASSERT_NXT(a_end_resyncs, clk, arst_n,
		in_beat && res_valid && res.kind == KIND_END, state_q == ST_WAIT_AA)

endmodule

>>> hw/rtl/srfd_queue.sv
// Short result queue between the parser and the output stage.
`include "sensor_row_frame_deframer_top_macros.svh"

module srfd_queue
	import srfd_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_data,
	output logic full,
	input  logic pop,
	output logic empty,
	output res_t head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	res_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			if (pop) rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			if (push && !pop) count_q <= count_q + CW'(1);
			else if (pop && !push) count_q <= count_q - CW'(1);
		end
	end

	`SRFD_ASSERT_IMP(a_no_overflow, clk, arst_n, push, !full || pop)
	`SRFD_ASSERT_IMP(a_no_underflow, clk, arst_n, pop, !empty)

endmodule

>>> hw/rtl/srfd_emit.sv
// Back end: derives the gray level and holds the packed result beat for the sink.
module srfd_emit
	import srfd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               avail,
	input  res_t               head,
	output logic               pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,
	output logic               m_tuser
);

	logic               valid_q;
	logic [TDATA_W-1:0] data_q;
	logic               kind_q;
	logic [7:0]         gray;

	assign pop  = avail && (!valid_q || m_tready);
	assign gray = head.pixel_value[13:6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= head.kind;
			data_q <= {6'b0, head.trailer_check, head.header_check, head.image_width,
				head.image_height, head.image_complete, head.trailer_ok,
				head.frame_command, gray, head.pixel_value, head.column, head.row};
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = kind_q;

endmodule

>>> hw/rtl/sensor_row_frame_deframer_top.sv
// Sensor row frame deframer: parses AA 55 00 framed rows into pixel and frame end beats.
// The block takes one byte beat per clock with no gaps of its own. A byte that completes
// a pixel pair or ends a frame puts its result into a QUEUE_DEPTH entry queue in the same
// cycle; the result then moves from the queue into the output register, which drives the
// master side, once that register is free. The input stalls only while the queue is full,
// so the sustained rate is one byte per cycle whenever the sink takes a beat every cycle;
// the parser's state register carries everything from one byte to the next.
module sensor_row_frame_deframer_top
	import srfd_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,  // [7:0] rx_byte
	output logic               m_tvalid,
	input  logic               m_tready,
	// [7:0] row, [16:8] column, [32:17] pixel_value, [40:33] pixel_gray,
	// [48:41] frame_command, [49] trailer_ok, [50] image_complete,
	// [57:51] image_height, [65:58] image_width, [81:66] header_check,
	// [97:82] trailer_check, [103:98] zero
	output logic [TDATA_W-1:0] m_tdata,
	output logic               m_tuser   // [0] kind
);

	logic in_beat;
	logic res_valid;
	res_t res;
	logic full;
	logic empty;
	logic pop;
	res_t head;

	assign s_tready = !full;
	assign in_beat  = s_tvalid && s_tready;

	srfd_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_beat   (in_beat),
		.rx_byte   (s_tdata),
		.res_valid (res_valid),
		.res       (res)
	);

	srfd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_beat && res_valid),
		.push_data (res),
		.full      (full),
		.pop       (pop),
		.empty     (empty),
		.head      (head)
	);

	srfd_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.avail    (!empty),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
